@@ hdl/maqs_pkg.sv @@
`default_nettype none

package maqs_pkg;

  // corners of one result run
  localparam int CORNERS = 4;
  // width of every coordinate field on the ports
  localparam int FIELD_W = 12;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CORNERS,
    OP_J,
    OP_L,
    OP_EMIT_RD,
    OP_EMIT_LD
  } op_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CORNERS,
    ST_JREAD,
    ST_LREAD,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    op_t        op;
    logic       wr_en;
    logic [1:0] corner;
    logic       small_set;
    logic       last;
    logic       dropped;
    logic       clear;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ hdl/maqs_point_if.sv @@
`default_nettype none

interface maqs_point_if;
  logic                          valid;
  logic                          ready;
  logic [maqs_pkg::FIELD_W-1:0]  point_x;
  logic [maqs_pkg::FIELD_W-1:0]  point_y;
  logic                          last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input last_point,
                output ready);
endinterface

`default_nettype wire

@@ hdl/maqs_corner_if.sv @@
`default_nettype none

interface maqs_corner_if;
  logic                          valid;
  logic                          ready;
  logic [maqs_pkg::FIELD_W-1:0]  corner_x;
  logic [maqs_pkg::FIELD_W-1:0]  corner_y;
  logic                          last_corner;
  logic                          points_dropped;

  modport source (output valid, output corner_x, output corner_y, output last_corner,
                  output points_dropped, input ready);
  modport sink (input valid, input corner_x, input corner_y, input last_corner,
                input points_dropped, output ready);
endinterface

`default_nettype wire

@@ hdl/maqs_dp.sv @@
`default_nettype none

module maqs_dp #(
  parameter int MAX_POINTS = 16,
  parameter int IW         = 4,
  parameter int SW         = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  maqs_pkg::cmd_t               cmd,
  input  logic [IW-1:0]                addr_a,
  input  logic [IW-1:0]                addr_b,
  input  logic [IW-1:0]                idx_i,
  input  logic [IW-1:0]                idx_j,
  input  logic [IW-1:0]                idx_k,
  input  logic [SW-1:0]                in_x,
  input  logic [SW-1:0]                in_y,
  output maqs_pkg::status_t            status,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [maqs_pkg::FIELD_W-1:0] corner_x,
  output logic [maqs_pkg::FIELD_W-1:0] corner_y,
  output logic                         last_corner,
  output logic                         points_dropped
);

  localparam int DW = SW + 1;
  localparam int PW = 2 * DW;
  localparam int FW = PW + 1;
  localparam int AW = FW + 1;

  // point store
  logic [SW-1:0] mem_x [MAX_POINTS];
  logic [SW-1:0] mem_y [MAX_POINTS];

  logic [SW-1:0] rd_ax, rd_ay, rd_bx, rd_by;
  logic [IW-1:0] rd_addr, emit_addr;
  logic          rd_en, search_op;

  maqs_pkg::op_t r_op, m_op, s_op;
  logic [IW-1:0] r_idx [maqs_pkg::CORNERS];
  logic [IW-1:0] m_idx [maqs_pkg::CORNERS];
  logic [IW-1:0] s_idx [maqs_pkg::CORNERS];
  logic [IW-1:0] d_idx [maqs_pkg::CORNERS];
  logic [IW-1:0] best_idx [maqs_pkg::CORNERS];

  logic signed [DW-1:0] dx, dy;
  logic signed [PW-1:0] m_p1, m_p2;
  logic signed [FW-1:0] s_f, fj;
  logic signed [AW-1:0] diff;
  logic [AW-1:0]        area_abs, d_area, best_area;
  logic                 d_valid, found;

  logic                          o_valid;
  logic [maqs_pkg::FIELD_W-1:0]  o_x, o_y;
  logic                          o_last, o_dropped;

  assign search_op = (cmd.op == maqs_pkg::OP_CORNERS) || (cmd.op == maqs_pkg::OP_J) ||
                     (cmd.op == maqs_pkg::OP_L);
  assign rd_en     = search_op || (cmd.op == maqs_pkg::OP_EMIT_RD);
  assign emit_addr = cmd.small_set ? IW'(cmd.corner) : best_idx[cmd.corner];
  assign rd_addr   = (cmd.op == maqs_pkg::OP_EMIT_RD) ? emit_addr : addr_a;
  assign found     = (best_area != '0);

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_x[addr_a] <= in_x;
      mem_y[addr_a] <= in_y;
    end
    if (rd_en) begin
      rd_ax <= mem_x[rd_addr];
      rd_ay <= mem_y[rd_addr];
      rd_bx <= mem_x[addr_b];
      rd_by <= mem_y[addr_b];
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      r_op    <= maqs_pkg::OP_NONE;
      m_op    <= maqs_pkg::OP_NONE;
      s_op    <= maqs_pkg::OP_NONE;
      d_valid <= 1'b0;
    end else begin
      r_op    <= search_op ? cmd.op : maqs_pkg::OP_NONE;
      m_op    <= ((r_op == maqs_pkg::OP_J) || (r_op == maqs_pkg::OP_L)) ? r_op
                                                                          : maqs_pkg::OP_NONE;
      s_op    <= m_op;
      d_valid <= (s_op == maqs_pkg::OP_L);
    end
  end

  assign diff     = AW'(s_f) - AW'(fj);
  assign area_abs = diff[AW-1] ? AW'(-diff) : AW'(diff);

  // f(p) = yp*(xk-xi) + xp*(yi-yk); area = |f(l) - f(j)|
  always_ff @(posedge clk) begin
    r_idx[0] <= idx_i;
    r_idx[1] <= idx_j;
    r_idx[2] <= idx_k;
    r_idx[3] <= addr_a;
    if (r_op == maqs_pkg::OP_CORNERS) begin
      dx <= $signed({1'b0, rd_bx}) - $signed({1'b0, rd_ax});
      dy <= $signed({1'b0, rd_ay}) - $signed({1'b0, rd_by});
    end
    m_p1  <= PW'($signed({1'b0, rd_ay})) * PW'(dx);
    m_p2  <= PW'($signed({1'b0, rd_ax})) * PW'(dy);
    m_idx <= r_idx;
    s_f   <= FW'(m_p1) + FW'(m_p2);
    s_idx <= m_idx;
    if (s_op == maqs_pkg::OP_J) begin
      fj <= s_f;
    end
    d_area <= area_abs;
    d_idx  <= s_idx;
  end

  // running best, first strict maximum wins
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      best_area <= '0;
      for (int c = 0; c < maqs_pkg::CORNERS; c++) begin
        best_idx[c] <= '0;
      end
    end else if (d_valid && (d_area > best_area)) begin
      best_area <= d_area;
      best_idx  <= d_idx;
    end
  end

  assign status.busy     = (r_op != maqs_pkg::OP_NONE) || (m_op != maqs_pkg::OP_NONE) ||
                           (s_op != maqs_pkg::OP_NONE) || d_valid;
  assign status.out_free = !o_valid || out_ready;

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (cmd.op == maqs_pkg::OP_EMIT_LD) begin
      o_valid <= 1'b1;
    end else if (out_ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == maqs_pkg::OP_EMIT_LD) begin
      o_x       <= (cmd.small_set || found) ? maqs_pkg::FIELD_W'(rd_ax) : '0;
      o_y       <= (cmd.small_set || found) ? maqs_pkg::FIELD_W'(rd_ay) : '0;
      o_last    <= cmd.last;
      o_dropped <= cmd.dropped;
    end
  end

  assign out_valid      = o_valid;
  assign corner_x       = o_x;
  assign corner_y       = o_y;
  assign last_corner    = o_last;
  assign points_dropped = o_dropped;

`ifndef SYNTHESIS
  a_emit_after_drain: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == maqs_pkg::OP_EMIT_RD) |-> !status.busy)
    else $error("corner read while area pipeline still busy");

  a_best_ordered: assert property (@(posedge clk) disable iff (rst)
    (best_area != '0) |-> ((best_idx[0] < best_idx[1]) && (best_idx[1] < best_idx[2]) &&
                           (best_idx[2] < best_idx[3])))
    else $error("best corner indices out of order");

  a_best_monotonic: assert property (@(posedge clk) disable iff (rst)
    !cmd.clear |=> (best_area >= $past(best_area)))
    else $error("best area fell without a clear");
`endif

endmodule

`default_nettype wire

@@ hdl/maqs_ctrl.sv @@
`default_nettype none

module maqs_ctrl #(
  parameter int MAX_POINTS = 16,
  parameter int IW         = 4,
  parameter int CW         = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  maqs_pkg::status_t status,
  output maqs_pkg::cmd_t    cmd,
  output logic [IW-1:0]     addr_a,
  output logic [IW-1:0]     addr_b,
  output logic [IW-1:0]     idx_i,
  output logic [IW-1:0]     idx_j,
  output logic [IW-1:0]     idx_k
);

  localparam int NW = CW + 1;

  maqs_pkg::state_t state, state_next;
  logic [CW-1:0] count;
  logic          dropped, small_set;
  logic [IW-1:0] i, j, k, l;
  logic [1:0]    corner;

  logic          accept, has_room, close_small, corner_last;
  logic          l_more, k_more, j_more, i_more;
  logic [NW-1:0] n_ext, count_after;

  assign accept      = in_valid && in_ready;
  assign has_room    = (count < CW'(MAX_POINTS));
  assign n_ext       = NW'(count);
  assign count_after = n_ext + NW'(has_room);
  assign close_small = (count_after <= NW'(maqs_pkg::CORNERS));
  assign l_more      = (NW'(l) + NW'(1) < n_ext);
  assign k_more      = (NW'(k) + NW'(2) < n_ext);
  assign j_more      = (NW'(j) + NW'(3) < n_ext);
  assign i_more      = (NW'(i) + NW'(4) < n_ext);
  assign corner_last = small_set ? (NW'(corner) + NW'(1) == n_ext)
                                 : (corner == 2'(maqs_pkg::CORNERS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      maqs_pkg::ST_LOAD: begin
        if (accept && in_last) begin
          state_next = close_small ? maqs_pkg::ST_EMIT_RD : maqs_pkg::ST_CORNERS;
        end
      end
      maqs_pkg::ST_CORNERS: state_next = maqs_pkg::ST_JREAD;
      maqs_pkg::ST_JREAD:   state_next = maqs_pkg::ST_LREAD;
      maqs_pkg::ST_LREAD: begin
        if (!l_more) begin
          state_next = (k_more || j_more || i_more) ? maqs_pkg::ST_CORNERS
                                                    : maqs_pkg::ST_DRAIN;
        end
      end
      maqs_pkg::ST_DRAIN: begin
        if (!status.busy) begin
          state_next = maqs_pkg::ST_EMIT_RD;
        end
      end
      maqs_pkg::ST_EMIT_RD: state_next = maqs_pkg::ST_EMIT_LD;
      maqs_pkg::ST_EMIT_LD: begin
        if (status.out_free) begin
          state_next = corner_last ? maqs_pkg::ST_LOAD : maqs_pkg::ST_EMIT_RD;
        end
      end
      default: state_next = maqs_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.op        = maqs_pkg::OP_NONE;
    cmd.wr_en     = 1'b0;
    cmd.corner    = corner;
    cmd.small_set = small_set;
    cmd.last      = corner_last;
    cmd.dropped   = dropped;
    cmd.clear     = 1'b0;
    addr_a        = l;
    addr_b        = k;
    idx_i         = i;
    idx_j         = j;
    idx_k         = k;
    unique case (state)
      maqs_pkg::ST_LOAD: begin
        in_ready  = 1'b1;
        cmd.wr_en = accept && has_room;
        addr_a    = count[IW-1:0];
      end
      maqs_pkg::ST_CORNERS: begin
        cmd.op = maqs_pkg::OP_CORNERS;
        addr_a = i;
      end
      maqs_pkg::ST_JREAD: begin
        cmd.op = maqs_pkg::OP_J;
        addr_a = j;
      end
      maqs_pkg::ST_LREAD: cmd.op = maqs_pkg::OP_L;
      maqs_pkg::ST_DRAIN: ;
      maqs_pkg::ST_EMIT_RD: cmd.op = maqs_pkg::OP_EMIT_RD;
      maqs_pkg::ST_EMIT_LD: begin
        if (status.out_free) begin
          cmd.op    = maqs_pkg::OP_EMIT_LD;
          cmd.clear = corner_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= maqs_pkg::ST_LOAD;
      count     <= '0;
      dropped   <= 1'b0;
      small_set <= 1'b0;
      corner    <= '0;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      l         <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        maqs_pkg::ST_LOAD: begin
          if (accept) begin
            if (has_room) begin
              count <= count + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (in_last) begin
              small_set <= close_small;
              corner    <= '0;
              i         <= '0;
              j         <= IW'(1);
              k         <= IW'(2);
            end
          end
        end
        maqs_pkg::ST_JREAD: l <= k + IW'(1);
        maqs_pkg::ST_LREAD: begin
          priority if (l_more) begin
            l <= l + IW'(1);
          end else if (k_more) begin
            k <= k + IW'(1);
          end else if (j_more) begin
            j <= j + IW'(1);
            k <= j + IW'(2);
          end else if (i_more) begin
            i <= i + IW'(1);
            j <= i + IW'(2);
            k <= i + IW'(3);
          end else begin
            corner <= '0;
          end
        end
        maqs_pkg::ST_EMIT_LD: begin
          if (status.out_free) begin
            if (corner_last) begin
              count   <= '0;
              dropped <= 1'b0;
            end else begin
              corner <= corner + 2'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_index_order: assert property (@(posedge clk) disable iff (rst)
    (state == maqs_pkg::ST_LREAD) |-> ((i < j) && (j < k) && (k < l) && (NW'(l) < n_ext)))
    else $error("subset indices out of order or beyond the set");

  a_search_large_only: assert property (@(posedge clk) disable iff (rst)
    (state == maqs_pkg::ST_CORNERS) |-> (n_ext > NW'(maqs_pkg::CORNERS)))
    else $error("search started on a set of four points or fewer");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    ((state == maqs_pkg::ST_EMIT_LD) && status.out_free && corner_last) |=>
      ((count == '0) && !dropped && (state == maqs_pkg::ST_LOAD)))
    else $error("set not cleared after its final corner");
`endif

endmodule

`default_nettype wire

@@ hdl/max_area_quadrilateral_select.sv @@
// Largest-area quadrilateral picker over a set of loaded points.
// pts (sink): one point word per accepted cycle; last_point closes the set.
//   While a set is loading a point is taken every cycle; points beyond
//   MAX_POINTS are not kept and the run reports points_dropped.
// corners (source): the result run, last_corner on its final word. A set of
//   four points or fewer comes back unchanged; otherwise the four corners of
//   the first subset i<j<k<l of greatest doubled shoelace area, or four words
//   at (0,0) when every area is zero.
// Search: the single area unit evaluates one fourth corner per cycle, after
//   the set-up steps ST_CORNERS and ST_JREAD for each (i,j,k) triple, and
//   the area pipeline is drained once the last subset has been read.
//   Each corner word then goes through a store read and an output load.
// No point is taken from the end of a set until its last corner word sits in
//   the output register; the next set may load while that word waits.
// A stalled receiver holds the output register and pauses the corner run.
// Reset (rst, synchronous) empties the set and the output register; the point
//   store itself is not cleared, only entries of the current set are read.
`default_nettype none

module max_area_quadrilateral_select #(
  parameter int MAX_POINTS = 16,
  parameter int COORD_BITS = 12
) (
  input  logic          clk,
  input  logic          rst,
  maqs_point_if.sink    pts,
  maqs_corner_if.source corners
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  // stored coordinate width: the port carries at most FIELD_W bits
  localparam int SW = (COORD_BITS < maqs_pkg::FIELD_W) ? COORD_BITS : maqs_pkg::FIELD_W;

  maqs_pkg::cmd_t    cmd;
  maqs_pkg::status_t status;
  logic [IW-1:0]     addr_a, addr_b, idx_i, idx_j, idx_k;

  // sequencer: loading, subset walk, drain and corner run
  maqs_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .IW         (IW),
    .CW         (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pts.valid),
    .in_last  (pts.last_point),
    .in_ready (pts.ready),
    .status   (status),
    .cmd      (cmd),
    .addr_a   (addr_a),
    .addr_b   (addr_b),
    .idx_i    (idx_i),
    .idx_j    (idx_j),
    .idx_k    (idx_k)
  );

  // point store, area pipeline, best tracker and output word register
  maqs_dp #(
    .MAX_POINTS (MAX_POINTS),
    .IW         (IW),
    .SW         (SW)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .addr_a         (addr_a),
    .addr_b         (addr_b),
    .idx_i          (idx_i),
    .idx_j          (idx_j),
    .idx_k          (idx_k),
    .in_x           (pts.point_x[SW-1:0]),
    .in_y           (pts.point_y[SW-1:0]),
    .status         (status),
    .out_valid      (corners.valid),
    .out_ready      (corners.ready),
    .corner_x       (corners.corner_x),
    .corner_y       (corners.corner_y),
    .last_corner    (corners.last_corner),
    .points_dropped (corners.points_dropped)
  );

endmodule

`default_nettype wire

@@ sim/tb_max_area_quadrilateral_select.sv @@
module tb_max_area_quadrilateral_select;
  localparam int CORNERS     = maqs_pkg::CORNERS;
  localparam int FIELD_W     = maqs_pkg::FIELD_W;

  localparam int MAX_POINTS  = 16;
  localparam int COORD_BITS  = 12;
  // longest receiver hold-off, long enough to back the block up into its input
  localparam int HOLD_CYCLES = 600;
  // quiet cycles before giving up
  localparam int QUIET_LIMIT = 20000;
  localparam int RAND_ITEMS  = 75;

  // coordinate patterns for the random sets
  typedef enum int {
    SET_WIDE,
    SET_NARROW,
    SET_EDGES,
    SET_LINE
  } set_mode_t;

  // one corner word as it leaves the block
  typedef struct packed {
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    logic               last;
    logic               dropped;
  } corner_word_t;

  // ---------------------------------------------------------------------------
  // point-set tracker: keeps its own copy of the loaded set, works out the
  // corner run when a set closes and checks the words that come back
  // ---------------------------------------------------------------------------
  class quad_scoreboard;
    logic [FIELD_W-1:0] px [MAX_POINTS];
    logic [FIELD_W-1:0] py [MAX_POINTS];
    int                 n_pts;
    bit                 dropped;
    corner_word_t       corner_q [$];
    int                 n_fail;

    // doubled shoelace area of four stored points, taken in the given order
    function longint dbl_area(int c0, int c1, int c2, int c3);
      int     sel [CORNERS];
      longint acc;
      sel = '{c0, c1, c2, c3};
      acc = 0;
      for (int a = 0; a < CORNERS; a++) begin
        acc += longint'(px[sel[a]]) * longint'(py[sel[(a + 1) % CORNERS]])
             - longint'(px[sel[(a + 1) % CORNERS]]) * longint'(py[sel[a]]);
      end
      return (acc < 0) ? -acc : acc;
    endfunction

    function void add_point(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y, logic last);
      longint       best;
      longint       ar;
      int           win [CORNERS];
      bit           found;
      corner_word_t w;
      if (n_pts < MAX_POINTS) begin
        px[n_pts] = x;
        py[n_pts] = y;
        n_pts++;
      end else begin
        dropped = 1'b1;
      end
      if (!last) return;
      if (n_pts <= CORNERS) begin
        // small set comes back as loaded
        for (int i = 0; i < n_pts; i++) begin
          w.x       = px[i];
          w.y       = py[i];
          w.last    = (i == n_pts - 1);
          w.dropped = dropped;
          corner_q  = {corner_q, w};
        end
      end else begin
        best  = 0;
        found = 1'b0;
        win   = '{0, 0, 0, 0};
        for (int i = 0; i < n_pts - 3; i++)
          for (int j = i + 1; j < n_pts - 2; j++)
            for (int k = j + 1; k < n_pts - 1; k++)
              for (int l = k + 1; l < n_pts; l++) begin
                ar = dbl_area(i, j, k, l);
                // first strictly larger area wins, ties keep the earlier subset
                if (ar > best) begin
                  best  = ar;
                  win   = '{i, j, k, l};
                  found = 1'b1;
                end
              end
        for (int c = 0; c < CORNERS; c++) begin
          w.x       = found ? px[win[c]] : '0;
          w.y       = found ? py[win[c]] : '0;
          w.last    = (c == CORNERS - 1);
          w.dropped = dropped;
          corner_q  = {corner_q, w};
        end
      end
      n_pts   = 0;
      dropped = 1'b0;
    endfunction

    function void check_corner(corner_word_t got);
      corner_word_t want;
      if (corner_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("unexpected corner word x=%0d y=%0d last=%0b dropped=%0b",
                   got.x, got.y, got.last, got.dropped);
        return;
      end
      want = corner_q.pop_front();
      if (got !== want) begin
        n_fail++;
        if (n_fail <= 10)
          $display("mismatch: exp x=%0d y=%0d l=%0b d=%0b, got x=%0d y=%0d l=%0b d=%0b",
                   want.x, want.y, want.last, want.dropped,
                   got.x, got.y, got.last, got.dropped);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  maqs_point_if  pts_if ();
  maqs_corner_if crn_if ();

  max_area_quadrilateral_select #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .pts     (pts_if),
    .corners (crn_if)
  );

  quad_scoreboard sb = new();

  // idle chances in percent, set by the stimulus process only
  int snd_idle = 18;
  int rcv_idle = 75;
  // bumped by the stimulus to ask the receiver for one long hold-off
  int hold_requests = 0;

  wire pt_accept  = pts_if.valid && pts_if.ready;
  wire crn_accept = crn_if.valid && crn_if.ready;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // both channels sampled on the edge that accepts the word
  always @(posedge clk) begin
    if (!rst && pt_accept)
      sb.add_point(pts_if.point_x, pts_if.point_y, pts_if.last_point);
    if (!rst && crn_accept)
      sb.check_corner({crn_if.corner_x, crn_if.corner_y, crn_if.last_corner,
                       crn_if.points_dropped});
  end

  // corner receiver: random back-pressure plus the long hold-off on request
  initial begin : corner_sink
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    crn_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        crn_if.ready <= 1'b0;
      end else begin
        crn_if.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // watchdog: a run that stops moving words is a failure
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (pt_accept || crn_accept) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // offer one point word, with random gaps ahead of it, until it is taken
  task automatic send_point(input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
                            input logic last);
    while ($urandom_range(99) < snd_idle) begin
      pts_if.valid <= 1'b0;
      @(posedge clk);
    end
    pts_if.valid      <= 1'b1;
    pts_if.point_x    <= x;
    pts_if.point_y    <= y;
    pts_if.last_point <= last;
    @(posedge clk);
    while (!pts_if.ready) @(posedge clk);
  endtask

  // a whole set of n points, the last one flagged
  task automatic send_set(input int n, input set_mode_t mode);
    int                 dx;
    int                 dy;
    int                 x0;
    int                 y0;
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    dx = $urandom_range(200);
    dy = $urandom_range(200);
    x0 = $urandom_range(200);
    y0 = $urandom_range(200);
    for (int p = 0; p < n; p++) begin
      case (mode)
        SET_WIDE: begin
          x = FIELD_W'($urandom_range(4095));
          y = FIELD_W'($urandom_range(4095));
        end
        SET_NARROW: begin
          // tiny grid, lots of equal and zero areas
          x = FIELD_W'($urandom_range(15));
          y = FIELD_W'($urandom_range(15));
        end
        SET_EDGES: begin
          x = $urandom_range(1) ? {FIELD_W{1'b1}} : '0;
          y = $urandom_range(1) ? {FIELD_W{1'b1}} : '0;
        end
        default: begin
          // points on one line, every area zero
          x = FIELD_W'(x0 + p * dx);
          y = FIELD_W'(y0 + p * dy);
        end
      endcase
      send_point(x, y, p == n - 1);
    end
  endtask

  // stop offering and let every expected corner word come back
  task automatic wait_drained();
    pts_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.corner_q.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int        rnd_items;
    int        set_no;
    int        n;
    int        pick;
    set_mode_t mode;
    rst               = 1'b1;
    pts_if.valid      = 1'b0;
    pts_if.point_x    = '0;
    pts_if.point_y    = '0;
    pts_if.last_point = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // single point at the top corner of the range
    send_point(12'hfff, 12'hfff, 1'b1);
    // two points, both extremes of x
    send_point(12'h000, 12'h000, 1'b0);
    send_point(12'hfff, 12'h000, 1'b1);
    // four points come back unchanged
    send_point(12'h000, 12'h000, 1'b0);
    send_point(12'hfff, 12'h000, 1'b0);
    send_point(12'hfff, 12'hfff, 1'b0);
    send_point(12'h000, 12'hfff, 1'b1);
    // collinear set, every area zero so the run is four words at the origin
    send_point(12'd0, 12'd0, 1'b0);
    send_point(12'd1, 12'd1, 1'b0);
    send_point(12'd2, 12'd2, 1'b0);
    send_point(12'd3, 12'd3, 1'b0);
    send_point(12'hfff, 12'hfff, 1'b1);
    // two subsets of equal area, the earlier must win
    send_point(12'd0, 12'd0, 1'b0);
    send_point(12'd100, 12'd0, 1'b0);
    send_point(12'd100, 12'd100, 1'b0);
    send_point(12'd0, 12'd100, 1'b0);
    send_point(12'd0, 12'd0, 1'b1);
    // crossing order at full range
    send_point(12'h000, 12'hfff, 1'b0);
    send_point(12'hfff, 12'h000, 1'b0);
    send_point(12'hfff, 12'hfff, 1'b0);
    send_point(12'h000, 12'h000, 1'b0);
    send_point(12'h800, 12'h800, 1'b1);
    // alternating bit patterns
    send_point(12'haaa, 12'h555, 1'b0);
    send_point(12'h555, 12'haaa, 1'b0);
    send_point(12'hfff, 12'h000, 1'b1);

    // sender pause until the block has handed back everything
    wait_drained();

    rnd_items = 0;
    set_no    = 0;
    while (rnd_items < RAND_ITEMS) begin
      // idling phases: sender light / receiver heavy, then swapped, then none
      if (rnd_items >= 2 * RAND_ITEMS / 3) begin
        snd_idle = 0;
        rcv_idle = 0;
      end else if (rnd_items >= RAND_ITEMS / 3) begin
        snd_idle = 75;
        rcv_idle = 18;
      end
      if (set_no == 0) begin
        // over capacity, the flagged point itself dropped
        n = MAX_POINTS + 1 + $urandom_range(2);
      end else if (set_no >= 2 && set_no <= 4) begin
        // short sets while the receiver holds off, so the block backs up
        if (set_no == 2) hold_requests++;
        n = 5 + $urandom_range(1);
      end else begin
        pick = $urandom_range(99);
        if (pick < 25) n = 1 + $urandom_range(3);
        else if (pick < 90) n = 5 + $urandom_range(3);
        else n = MAX_POINTS + $urandom_range(3);
      end
      pick = $urandom_range(99);
      if (pick < 55) mode = SET_WIDE;
      else if (pick < 75) mode = SET_NARROW;
      else if (pick < 85) mode = SET_EDGES;
      else mode = SET_LINE;
      send_set(n, mode);
      rnd_items += n;
      set_no++;
    end

    wait_drained();
    // keep the clock running to catch any stray corner word
    repeat (40) @(posedge clk);
    if (sb.n_fail == 0 && sb.corner_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
